// ===== sv/mexp_pkg.sv =====
// Shared types, constants and the control store of the modular exponentiation block.
package mexp_pkg;

  // Fixed width of every operand and result field on the channels.
  localparam int unsigned DATA_W    = 64;
  // Default operand width used inside the datapath.
  localparam int unsigned WIDTH_DEF = 64;

  // Control store addressing.
  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_LOAD      = 4'd0;
  localparam upc_t UPC_INIT      = 4'd1;
  localparam upc_t UPC_RED       = 4'd2;
  localparam upc_t UPC_RED_WAIT  = 4'd3;
  localparam upc_t UPC_SQ        = 4'd4;
  localparam upc_t UPC_SQ_WAIT   = 4'd5;
  localparam upc_t UPC_TEST      = 4'd6;
  localparam upc_t UPC_MULB      = 4'd7;
  localparam upc_t UPC_MULB_WAIT = 4'd8;
  localparam upc_t UPC_NEXT      = 4'd9;
  localparam upc_t UPC_OUT       = 4'd10;

  // Datapath action of a step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_INIT,
    ACT_MUL_RED,
    ACT_MUL_SQ,
    ACT_MUL_B,
    ACT_NEXT,
    ACT_OUT
  } mexp_act_e;

  // What a step waits for before it completes.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_IN,
    HOLD_MUL,
    HOLD_OUT
  } mexp_hold_e;

  // Jump condition, evaluated when the step completes.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_ERR,
    COND_BIT_CLR,
    COND_MORE
  } mexp_cond_e;

  // Destination of a finished modular product.
  typedef enum logic {
    DST_B,
    DST_R
  } mexp_dst_e;

  typedef struct packed {
    mexp_act_e  act;
    mexp_hold_e hold;
    mexp_cond_e cond;
    upc_t       target;
  } mexp_uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    mexp_act_e act;
    logic      go;
  } mexp_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic in_valid;
    logic mul_done;
    logic out_free;
    logic mod_zero;
    logic bit_clr;
    logic more_bits;
  } mexp_stat_t;

  function automatic mexp_uword_t mexp_uw(mexp_act_e act, mexp_hold_e hold,
                                          mexp_cond_e cond, upc_t target);
    mexp_uword_t w;
    w.act    = act;
    w.hold   = hold;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // The microprogram: load, reduce the base, then square per bit, multiply per set bit.
  function automatic mexp_uword_t mexp_ucode(upc_t pc);
    mexp_uword_t w;
    unique case (pc)
      UPC_LOAD:      w = mexp_uw(ACT_LOAD,    HOLD_IN,   COND_NEVER,   UPC_LOAD);
      UPC_INIT:      w = mexp_uw(ACT_INIT,    HOLD_NONE, COND_ERR,     UPC_OUT);
      UPC_RED:       w = mexp_uw(ACT_MUL_RED, HOLD_NONE, COND_NEVER,   UPC_LOAD);
      UPC_RED_WAIT:  w = mexp_uw(ACT_NONE,    HOLD_MUL,  COND_NEVER,   UPC_LOAD);
      UPC_SQ:        w = mexp_uw(ACT_MUL_SQ,  HOLD_NONE, COND_NEVER,   UPC_LOAD);
      UPC_SQ_WAIT:   w = mexp_uw(ACT_NONE,    HOLD_MUL,  COND_NEVER,   UPC_LOAD);
      UPC_TEST:      w = mexp_uw(ACT_NONE,    HOLD_NONE, COND_BIT_CLR, UPC_NEXT);
      UPC_MULB:      w = mexp_uw(ACT_MUL_B,   HOLD_NONE, COND_NEVER,   UPC_LOAD);
      UPC_MULB_WAIT: w = mexp_uw(ACT_NONE,    HOLD_MUL,  COND_NEVER,   UPC_LOAD);
      UPC_NEXT:      w = mexp_uw(ACT_NEXT,    HOLD_NONE, COND_MORE,    UPC_SQ);
      UPC_OUT:       w = mexp_uw(ACT_OUT,     HOLD_OUT,  COND_ALWAYS,  UPC_LOAD);
      default:       w = mexp_uw(ACT_NONE,    HOLD_NONE, COND_ALWAYS,  UPC_LOAD);
    endcase
    return w;
  endfunction

endpackage

// ===== sv/mexp_if.sv =====
// Valid/ready channel interfaces for the operand and result beats.
interface mexp_in_if import mexp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base_value;
  logic [DATA_W-1:0] exponent_value;
  logic [DATA_W-1:0] modulus_value;

  modport source (output valid, base_value, exponent_value, modulus_value, input ready);
  modport sink   (input valid, base_value, exponent_value, modulus_value, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] power_result;
  logic              modulus_error;

  modport source (output valid, power_result, modulus_error, input ready);
  modport sink   (input valid, power_result, modulus_error, output ready);
endinterface

// ===== sv/mexp_mulmod.sv =====
// Interleaved shift-and-add modular multiplier, one multiplier bit per cycle.
module mexp_mulmod import mexp_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [WIDTH-1:0] res_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] a_q, a_d;
  logic [WIDTH-1:0] sb_q, sb_d;
  logic [WIDTH-1:0] m_q, m_d;

  logic [WIDTH+1:0] sum;
  logic [WIDTH+1:0] m1;
  logic [WIDTH+1:0] m2;
  logic [WIDTH+1:0] red;

  // The running value and the addend are below the modulus, so 2*acc + a stays
  // below three times the modulus and at most two subtractions bring it back.
  always_comb begin
    m1  = (WIDTH+2)'(m_q);
    m2  = m1 << 1;
    sum = ((WIDTH+2)'(acc_q) << 1) + (sb_q[WIDTH-1] ? (WIDTH+2)'(a_q) : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    sb_d   = sb_q;
    m_d    = m_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      a_d    = a_i;
      sb_d   = b_i;
      m_d    = m_i;
    end else if (busy_q) begin
      acc_d = red[WIDTH-1:0];
      sb_d  = sb_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WIDTH-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    sb_q  <= sb_d;
    m_q   <= m_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier started while busy");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (acc_q < m_q))
    else $error("partial product not reduced below the modulus");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && !$past(done_q))
    else $error("done is not a single pulse after the scan");
`endif

endmodule

// ===== sv/mexp_seq.sv =====
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
module mexp_seq import mexp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  mexp_stat_t stat_i,
  output mexp_ctrl_t ctrl_o
);

  upc_t        pc_q, pc_d;
  mexp_uword_t word;
  logic        go;
  logic        take;

  always_comb begin
    word = mexp_ucode(pc_q);

    unique case (word.hold)
      HOLD_NONE: go = 1'b1;
      HOLD_IN:   go = stat_i.in_valid;
      HOLD_MUL:  go = stat_i.mul_done;
      HOLD_OUT:  go = stat_i.out_free;
    endcase

    unique case (word.cond)
      COND_NEVER:   take = 1'b0;
      COND_ALWAYS:  take = 1'b1;
      COND_ERR:     take = stat_i.mod_zero;
      COND_BIT_CLR: take = stat_i.bit_clr;
      COND_MORE:    take = stat_i.more_bits;
      default:      take = 1'b0;
    endcase

    if (!go) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = word.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end

    ctrl_o.act = word.act;
    ctrl_o.go  = go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mul_done |-> (word.hold == HOLD_MUL))
    else $error("product finished outside a wait step");
`endif

endmodule

// ===== sv/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: operand registers and datapath.
// Between the input beat and the result beat each item runs the base reduction, one
// squaring per exponent bit and one multiply per set bit, each a modular product. A zero
// modulus skips all of it. The block takes one item at a time; a new operand beat is taken
// as soon as the previous result sits in the output register, even if that result has not
// been taken yet.
// Reset: rst_ni clears the step counter, the multiplier control and the output valid.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mexp_in_if.sink   in_i,
  mexp_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);

  // Operand and running-value registers. The base register holds the base reduced
  // modulo the modulus after the reduction step; the exponent shifts left one bit per
  // loop pass so that its top bit is always the bit under scan.
  logic [WIDTH-1:0]  b_q, b_d;
  logic [WIDTH-1:0]  e_q, e_d;
  logic [WIDTH-1:0]  m_q, m_d;
  logic [WIDTH-1:0]  r_q, r_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  mexp_dst_e         dst_q, dst_d;

  // Output register, which decouples the result beat from the next operand beat.
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_res_q, out_res_d;
  logic              out_err_q, out_err_d;

  mexp_ctrl_t        ctrl;
  mexp_stat_t        stat;

  logic              in_accept;
  logic              mul_start;
  logic [WIDTH-1:0]  mul_a;
  logic [WIDTH-1:0]  mul_b;
  logic              mul_busy;
  logic              mul_done;
  logic [WIDTH-1:0]  mul_res;
  logic [WIDTH-1:0]  one_w;
  logic              mod_zero;

  assign one_w    = WIDTH'(1);
  assign mod_zero = (m_q == '0);

  mexp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (m_q),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  assign in_i.ready = (ctrl.act == ACT_LOAD);
  assign in_accept  = in_i.valid && in_i.ready;

  always_comb begin
    stat.in_valid  = in_i.valid;
    stat.mul_done  = mul_done;
    stat.out_free  = !out_valid_q || out_o.ready;
    stat.mod_zero  = mod_zero;
    stat.bit_clr   = !e_q[WIDTH-1];
    stat.more_bits = (cnt_q != '0);
  end

  // Operand selection for the multiplier. The base reduction is the product 1 * base,
  // which the interleaved scan turns into a plain remainder.
  always_comb begin
    unique case (ctrl.act)
      ACT_MUL_RED: begin
        mul_a = one_w;
        mul_b = b_q;
      end
      ACT_MUL_SQ: begin
        mul_a = r_q;
        mul_b = r_q;
      end
      default: begin
        mul_a = r_q;
        mul_b = b_q;
      end
    endcase
    mul_start = ctrl.go && ((ctrl.act == ACT_MUL_RED) || (ctrl.act == ACT_MUL_SQ) ||
                            (ctrl.act == ACT_MUL_B));
  end

  always_comb begin
    b_d         = b_q;
    e_d         = e_q;
    m_d         = m_q;
    r_d         = r_q;
    cnt_d       = cnt_q;
    dst_d       = dst_q;
    out_res_d   = out_res_q;
    out_err_d   = out_err_q;
    out_valid_d = out_valid_q && !out_o.ready;

    // A finished product lands where the step that launched it asked.
    if (mul_done) begin
      if (dst_q == DST_B) begin
        b_d = mul_res;
      end else begin
        r_d = mul_res;
      end
    end

    if (ctrl.go) begin
      unique case (ctrl.act)
        ACT_LOAD: begin
          b_d = in_i.base_value[WIDTH-1:0];
          e_d = in_i.exponent_value[WIDTH-1:0];
          m_d = in_i.modulus_value[WIDTH-1:0];
        end
        ACT_INIT: begin
          // One modulo the modulus: zero when the modulus is one.
          r_d   = (m_q == one_w) ? '0 : one_w;
          cnt_d = CNT_W'(WIDTH-1);
        end
        ACT_MUL_RED: begin
          dst_d = DST_B;
        end
        ACT_MUL_SQ, ACT_MUL_B: begin
          dst_d = DST_R;
        end
        ACT_NEXT: begin
          e_d = e_q << 1;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        ACT_OUT: begin
          // A zero modulus skips the scan and reports an error with a zero result.
          out_res_d   = mod_zero ? '0 : DATA_W'(r_q);
          out_err_d   = mod_zero;
          out_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dst_q       <= DST_R;
    end else begin
      out_valid_q <= out_valid_d;
      dst_q       <= dst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q       <= b_d;
    e_q       <= e_d;
    m_q       <= m_d;
    r_q       <= r_d;
    cnt_q     <= cnt_d;
    out_res_q <= out_res_d;
    out_err_q <= out_err_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.power_result  = out_res_q;
  assign out_o.modulus_error = out_err_q;

`ifndef SYNTHESIS
  a_err_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_res_q == '0))
    else $error("error beat carries a nonzero result");

  a_accept_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> !mul_busy)
    else $error("operands loaded while a product is in flight");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_res_q)))
    else $error("pending result beat was overwritten");
`endif

endmodule

// ===== tb/sv/modular_exponentiation_test.sv =====
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 100ps

module modular_exponentiation_test import mexp_pkg::*;;

  // Operand width of the instance. The predictor masks the operands to it, as the block does.
  localparam int unsigned OPW = WIDTH_DEF;

  // The limit covers every item at its worst case, with a squaring and a multiply for
  // every exponent bit, plus the sender gaps and receiver stalls, several times over.
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  // Quiet cycles after the last result, so that a stray extra result is still seen.
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 80;

  localparam logic [DATA_W-1:0] ALL_ONES    = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] PRIME_64    = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [DATA_W-1:0] TOP_BIT     = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] GOLDILOCKS  = 64'hFFFF_FFFF_0000_0001;

  // Idle rates in percent. The run is cut into four phases by the number of operand
  // beats taken: no idling, a slow sender, a slow receiver, and light idling on both sides.
  localparam int unsigned IDLE_HEAVY = 62;
  localparam int unsigned IDLE_LIGHT = 6;

  typedef struct packed {
    logic [DATA_W-1:0] base_value;
    logic [DATA_W-1:0] exponent_value;
    logic [DATA_W-1:0] modulus_value;
  } operands_t;

  typedef struct packed {
    logic [DATA_W-1:0] power_result;
    logic              modulus_error;
  } power_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mexp_in_if  operand_if ();
  mexp_out_if result_if ();

  modular_exponentiation #(
    .WIDTH (OPW)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (operand_if),
    .out_o  (result_if)
  );

  // Operand beats still to be sent, and the powers expected back, oldest first.
  operands_t   operand_q[$];
  power_t      power_due_q[$];
  int unsigned operand_total  = 0;
  int unsigned operands_taken = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Expected power. Unlike the block, this scans the exponent from the low end and
  // forms each modular product at double width, so the two share no structure.
  function automatic power_t modexp_predict(operands_t op);
    logic [OPW-1:0]   b;
    logic [OPW-1:0]   e;
    logic [OPW-1:0]   m;
    logic [2*OPW-1:0] acc;
    logic [2*OPW-1:0] sq;
    logic [2*OPW-1:0] m_wide;
    int unsigned      k;
    power_t           p;
    b = op.base_value[OPW-1:0];
    e = op.exponent_value[OPW-1:0];
    m = op.modulus_value[OPW-1:0];
    p = '0;
    if (m == '0) begin
      // A zero modulus is flagged and the power is forced to zero.
      p.modulus_error = 1'b1;
    end else begin
      m_wide = {{OPW{1'b0}}, m};
      acc    = 1 % m_wide;
      sq     = {{OPW{1'b0}}, b} % m_wide;
      for (k = 0; k < OPW; k++) begin
        if (e[k]) begin
          acc = (acc * sq) % m_wide;
        end
        sq = (sq * sq) % m_wide;
      end
      p.power_result[OPW-1:0] = acc[OPW-1:0];
    end
    return p;
  endfunction

  function automatic int unsigned run_phase();
    int unsigned ph;
    ph = (operand_total == 0) ? 0 : (operands_taken * 4) / operand_total;
    return (ph > 3) ? 3 : ph;
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (run_phase())
      1: begin
        return IDLE_HEAVY;
      end
      3: begin
        return IDLE_LIGHT;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (run_phase())
      2: begin
        return IDLE_HEAVY;
      end
      3: begin
        return IDLE_LIGHT;
      end
      default: begin
        return 0;
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic queue_operands(logic [DATA_W-1:0] b, logic [DATA_W-1:0] e,
                                logic [DATA_W-1:0] m);
    operands_t op;
    op.base_value     = b;
    op.exponent_value = e;
    op.modulus_value  = m;
    operand_q.push_back(op);
  endtask

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Driver. At each edge it first records a beat the block has just taken, then
  // decides what the channel carries next. The valid line is written once per edge,
  // so back-to-back beats never see valid dropped and raised in the same step.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      operand_if.valid          <= 1'b0;
      operand_if.base_value     <= '0;
      operand_if.exponent_value <= '0;
      operand_if.modulus_value  <= '0;
    end else begin
      if (operand_if.valid && operand_if.ready) begin
        power_due_q.push_back(modexp_predict(operands_t'{
          base_value:     operand_if.base_value,
          exponent_value: operand_if.exponent_value,
          modulus_value:  operand_if.modulus_value}));
        operands_taken <= operands_taken + 1;
      end
      if (!operand_if.valid || operand_if.ready) begin
        if (operand_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          operand_if.base_value     <= operand_q[0].base_value;
          operand_if.exponent_value <= operand_q[0].exponent_value;
          operand_if.modulus_value  <= operand_q[0].modulus_value;
          operand_if.valid          <= 1'b1;
          void'(operand_q.pop_front());
        end else begin
          operand_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result beat is compared field by field with the oldest expectation,
  // and ready is redrawn every cycle so that stalls land on any phase of the work.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (power_due_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: power=%h error=%b",
                                    result_if.power_result, result_if.modulus_error));
        end else begin
          if (result_if.power_result !== power_due_q[0].power_result) begin
            report_mismatch($sformatf("power_result %h, expected %h",
                                      result_if.power_result, power_due_q[0].power_result));
          end
          if (result_if.modulus_error !== power_due_q[0].modulus_error) begin
            report_mismatch($sformatf("modulus_error %b, expected %b",
                                      result_if.modulus_error, power_due_q[0].modulus_error));
          end
          void'(power_due_q.pop_front());
        end
      end
      result_if.ready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modular_exponentiation_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned      n;
    int unsigned      pick;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] e;
    logic [DATA_W-1:0] m;

    rst_ni = 1'b0;

    // Directed beats: zero modulus, modulus one, zero exponent, zero base,
    // a base at or above the modulus, and the all-ones corners of each field.
    queue_operands(64'd5, 64'd3, 64'd0);
    queue_operands(ALL_ONES, ALL_ONES, 64'd0);
    queue_operands(64'd0, 64'd0, 64'd0);
    queue_operands(64'd7, 64'd13, 64'd1);
    queue_operands(ALL_ONES, 64'd0, 64'd1);
    queue_operands(64'd123, 64'd0, 64'd1000);
    queue_operands(64'd0, 64'd0, ALL_ONES);
    queue_operands(64'd0, 64'd5, 64'd97);
    queue_operands(ALL_ONES, ALL_ONES, ALL_ONES);
    queue_operands(ALL_ONES, ALL_ONES, PRIME_64);
    queue_operands(64'd97, 64'd5, 64'd97);
    queue_operands(64'd1000, 64'd3, 64'd7);
    queue_operands(64'd2, 64'd63, ALL_ONES);
    queue_operands(64'd2, 64'd64, TOP_BIT);
    queue_operands(64'd3, ALL_ONES, 64'd2);
    queue_operands(ALL_ONES, 64'd1, TOP_BIT | 64'd1);
    queue_operands(TOP_BIT, 64'd2, PRIME_64);
    queue_operands(64'd12345, 64'd65537, GOLDILOCKS);
    queue_operands(64'd1, ALL_ONES, ALL_ONES - 64'd1);
    queue_operands(ALL_ONES - 64'd1, 64'd2, ALL_ONES);
    queue_operands(PRIME_64 - 64'd1, PRIME_64 - 64'd1, PRIME_64);

    // Random beats. Most use full-width fields; the rest lean on short moduli,
    // the zero and one moduli, and short exponents.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      b    = rand_word();
      e    = rand_word();
      m    = rand_word();
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (m == '0) begin
          m = 64'd3;
        end
      end else if (pick < 70) begin
        m = 64'($urandom_range(1000, 2));
      end else if (pick < 82) begin
        m = m >> $urandom_range(63);
        b = b >> $urandom_range(63);
      end else if (pick < 87) begin
        m = '0;
      end else if (pick < 91) begin
        m = 64'd1;
      end else begin
        e = e >> $urandom_range(63, 56);
      end
      queue_operands(b, e, m);
    end
    operand_total = operand_q.size();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every beat taken and every expected result back, then a quiet stretch.
    while (operands_taken < operand_total || power_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("modular_exponentiation_test OK");
    end else begin
      $display("modular_exponentiation_test NOT OK");
    end
    $finish;
  end

endmodule
